// ===== design/scio_pkg.sv =====
// Shared types, codes and constants for the SUBLEQ core with I/O ports.
package scio_pkg;

    localparam int unsigned MEM_DEPTH_DEF = 65536;
    localparam int unsigned WORD_W        = 16;

    localparam logic [WORD_W-1:0] HALT_PC = 16'h8000;
    localparam logic [WORD_W-1:0] IO_BASE = 16'hFFF0;   // -16 as a signed word

    // Command codes.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Input ports, selected when operand a is an I/O address.
    localparam logic [4:0] PORT_KEY      = 5'd1;
    localparam logic [4:0] PORT_TX_STAT  = 5'd2;
    localparam logic [4:0] PORT_RX_LEN   = 5'd3;
    localparam logic [4:0] PORT_EPOCH_LO = 5'd4;
    localparam logic [4:0] PORT_EPOCH_HI = 5'd5;

    // Output ports, selected when operand b is an I/O address.
    localparam logic [4:0] PORT_CHAR_OUT = 5'd1;
    localparam logic [4:0] PORT_TX_LEN   = 5'd2;
    localparam logic [4:0] PORT_DELAY    = 5'd4;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CHAR  = 3'd1,
        EV_DELAY = 3'd2,
        EV_TX    = 3'd3,
        EV_RX    = 3'd4
    } io_event_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FETCH_B,
        S_FETCH_C,
        S_DECODE,
        S_OPER_B,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [15:0] data;
        logic [15:0] key_in;
        logic [15:0] tx_status;
        logic [15:0] rx_length;
        logic [31:0] epoch_seconds;
    } req_t;

    // Port number 1..16 when the word is -1..-16 as a signed value, else 0.
    function automatic logic [4:0] port_of(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] neg;
        neg = WORD_W'(~w + 16'd1);
        return (w >= IO_BASE) ? neg[4:0] : 5'd0;
    endfunction

    function automatic logic [WORD_W-1:0] negate(input logic [WORD_W-1:0] w);
        return WORD_W'(16'd0 - w);
    endfunction

endpackage

// ===== design/scio_req_if.sv =====
// Command channel of the SUBLEQ core: valid/ready handshake with the command payload.
interface scio_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [15:0] data;
    logic [15:0] key_in;
    logic [15:0] tx_status;
    logic [15:0] rx_length;
    logic [31:0] epoch_seconds;

    modport source (
        output valid, command, address, data, key_in, tx_status, rx_length, epoch_seconds,
        input  ready
    );
    modport sink (
        input  valid, command, address, data, key_in, tx_status, rx_length, epoch_seconds,
        output ready
    );
endinterface

// ===== design/scio_rsp_if.sv =====
// Result channel of the SUBLEQ core: valid/ready handshake with the result payload.
interface scio_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [15:0] next_pc;
    logic        halted;
    logic [2:0]  io_event;
    logic [15:0] io_value;

    modport source (
        output valid, read_data, next_pc, halted, io_event, io_value,
        input  ready
    );
    modport sink (
        input  valid, read_data, next_pc, halted, io_event, io_value,
        output ready
    );
endinterface

// ===== design/subleq_core_with_io.sv =====
// SUBLEQ core with I/O ports over a single-port word memory, one result per command.
//
// A 16-bit SUBLEQ processor whose program and data live in one single-port synchronous
// memory with registered read data. Each command transaction is held in an input
// register and worked off by a sequencer that owns the memory port; its result goes to
// an output register, so a new command is taken while the previous result still waits.
// An execute command with no I/O operand uses the memory port six times (fetch a, b
// and c, read m[a], read m[b], write m[b]); the input register frees only when its
// result moves to the output register. Memory contents are undefined after reset until
// written; there is no clearing pass.
module subleq_core_with_io
    import scio_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    scio_req_if.sink    req,
    scio_rsp_if.source  rsp
);

    localparam int unsigned AW = $clog2(MEM_DEPTH);

    logic [WORD_W-1:0] mem [MEM_DEPTH];
    logic [WORD_W-1:0] mem_q;
    logic              mem_en;
    logic              mem_we;
    logic [WORD_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;

    state_t state_reg, state_next;

    logic        pend_valid_reg;
    req_t        item_reg;

    logic [WORD_W-1:0] pc_reg, pc_next;
    logic [WORD_W-1:0] txlen_reg, txlen_next;
    logic [31:0]       epoch_reg, epoch_next;

    logic [WORD_W-1:0] a_reg, b_reg, c_reg, va_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_read_data_reg, out_pc_reg, out_value_reg;
    io_event_t         out_event_reg;

    logic              out_free;
    logic              fire;
    logic [WORD_W-1:0] res_read_data, res_value;
    io_event_t         res_event;

    logic [WORD_W-1:0] pc_plus3;
    logic [4:0]        a_port, b_port;
    logic [WORD_W-1:0] diff;

    assign out_free = !out_valid_reg || rsp.ready;
    assign pc_plus3 = WORD_W'(pc_reg + 16'd3);
    assign a_port   = port_of(a_reg);
    assign b_port   = port_of(b_reg);
    assign diff     = WORD_W'(mem_q - va_reg);

    assign req.ready     = !pend_valid_reg;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_read_data_reg;
    assign rsp.next_pc   = out_pc_reg;
    assign rsp.halted    = out_pc_reg[WORD_W-1];
    assign rsp.io_event  = out_event_reg;
    assign rsp.io_value  = out_value_reg;

    // Single-port word memory, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
                mem[mem_addr[AW-1:0]] <= mem_wdata;
            else
                mem_q <= mem[mem_addr[AW-1:0]];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pend_valid_reg && item_reg.command == CMD_READ)
                    state_next = S_READ;
                else if (pend_valid_reg && item_reg.command == CMD_EXEC && !pc_reg[WORD_W-1])
                    state_next = S_FETCH_B;
            end
            S_READ:    if (out_free) state_next = S_IDLE;
            S_FETCH_B: state_next = S_FETCH_C;
            S_FETCH_C: state_next = S_DECODE;
            S_DECODE:
            begin
                if (a_port != 5'd0)
                begin
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                    state_next = S_OPER_B;
            end
            S_OPER_B:
            begin
                if (b_port != 5'd0)
                begin
                    if (out_free)
                        state_next = S_IDLE;
                end
                else
                    state_next = S_WRITE;
            end
            S_WRITE:   if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Memory port, result and architectural updates for each state.
    always_comb
    begin
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = pc_reg;
        mem_wdata     = item_reg.data;
        fire          = 1'b0;
        res_read_data = '0;
        res_event     = EV_NONE;
        res_value     = '0;
        pc_next       = pc_reg;
        txlen_next    = txlen_reg;
        epoch_next    = epoch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pend_valid_reg)
                begin
                    case (item_reg.command)
                        CMD_LOAD:
                        begin
                            if (out_free)
                            begin
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                mem_addr  = item_reg.address;
                                mem_wdata = item_reg.data;
                                fire      = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            mem_en   = 1'b1;
                            mem_addr = item_reg.address;
                        end
                        CMD_EXEC:
                        begin
                            if (pc_reg[WORD_W-1])
                                fire = out_free;
                            else
                            begin
                                mem_en   = 1'b1;
                                mem_addr = pc_reg;
                            end
                        end
                        default: fire = out_free;
                    endcase
                end
            end
            S_READ:
            begin
                fire          = out_free;
                res_read_data = mem_q;
            end
            S_FETCH_B:
            begin
                mem_en   = 1'b1;
                mem_addr = WORD_W'(pc_reg + 16'd1);
            end
            S_FETCH_C:
            begin
                mem_en   = 1'b1;
                mem_addr = WORD_W'(pc_reg + 16'd2);
            end
            S_DECODE:
            begin
                if (a_port != 5'd0)
                begin
                    fire     = out_free;
                    mem_addr = b_reg;
                    if (out_free)
                    begin
                        pc_next = pc_plus3;
                        case (a_port)
                            PORT_KEY:
                            begin
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                mem_wdata = item_reg.key_in;
                            end
                            PORT_TX_STAT:
                            begin
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                mem_wdata = negate(item_reg.tx_status);
                                res_event = EV_TX;
                                res_value = txlen_reg;
                            end
                            PORT_RX_LEN:
                            begin
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                mem_wdata = negate(item_reg.rx_length);
                                res_event = EV_RX;
                            end
                            PORT_EPOCH_LO:
                            begin
                                mem_en     = 1'b1;
                                mem_we     = 1'b1;
                                epoch_next = item_reg.epoch_seconds;
                                mem_wdata  = negate(item_reg.epoch_seconds[15:0]);
                            end
                            PORT_EPOCH_HI:
                            begin
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                mem_wdata = negate(epoch_reg[31:16]);
                            end
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    mem_en   = 1'b1;
                    mem_addr = a_reg;
                end
            end
            S_OPER_B:
            begin
                if (b_port != 5'd0)
                begin
                    fire = out_free;
                    if (out_free)
                    begin
                        pc_next = pc_plus3;
                        case (b_port)
                            PORT_CHAR_OUT:
                            begin
                                res_event = EV_CHAR;
                                res_value = {8'd0, mem_q[7:0]};
                            end
                            PORT_TX_LEN: txlen_next = mem_q;
                            PORT_DELAY:
                            begin
                                res_event = EV_DELAY;
                                res_value = mem_q;
                            end
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    mem_en   = 1'b1;
                    mem_addr = b_reg;
                end
            end
            S_WRITE:
            begin
                fire      = out_free;
                mem_addr  = b_reg;
                mem_wdata = diff;
                if (out_free)
                begin
                    mem_en  = 1'b1;
                    mem_we  = 1'b1;
                    pc_next = (diff == '0 || diff[WORD_W-1]) ? c_reg : pc_plus3;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= '0;
            txlen_reg      <= '0;
            epoch_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            txlen_reg <= txlen_next;
            epoch_reg <= epoch_next;
            if (req.valid && req.ready)
                pend_valid_reg <= 1'b1;
            else if (fire)
                pend_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.command       <= req.command;
            item_reg.address       <= req.address;
            item_reg.data          <= req.data;
            item_reg.key_in        <= req.key_in;
            item_reg.tx_status     <= req.tx_status;
            item_reg.rx_length     <= req.rx_length;
            item_reg.epoch_seconds <= req.epoch_seconds;
        end
        if (state_reg == S_FETCH_B)
            a_reg <= mem_q;
        if (state_reg == S_FETCH_C)
            b_reg <= mem_q;
        if (state_reg == S_DECODE)
            c_reg <= mem_q;
        if (state_reg == S_OPER_B)
            va_reg <= mem_q;
        if (fire)
        begin
            out_read_data_reg <= res_read_data;
            out_pc_reg        <= pc_next;
            out_event_reg     <= res_event;
            out_value_reg     <= res_value;
        end
    end

`ifndef NO_ASSERTIONS
    a_pc_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pc_reg))
        else $error("program counter changed without a completed transaction");

    a_sequencer_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_valid_reg |-> state_reg == S_IDLE)
        else $error("sequencer busy with no command held");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_en && mem_we) |-> (fire && (state_reg == S_IDLE || state_reg == S_DECODE
                                         || state_reg == S_WRITE)))
        else $error("memory written outside a completing step");

    a_halted_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && pc_reg[WORD_W-1]) |-> (res_event == EV_NONE && pc_next == pc_reg))
        else $error("halted core executed an instruction");
`endif

endmodule
